// ===== rtl/vcpu_pkg.sv =====
`default_nettype none
package vcpu_pkg;

    localparam int REG_COUNT = 16;
    localparam int RIDX_W    = 4;

    localparam logic [3:0] OP_LOAD   = 4'h1;
    localparam logic [3:0] OP_LOADI  = 4'h2;
    localparam logic [3:0] OP_STORE  = 4'h3;
    localparam logic [3:0] OP_MOVE   = 4'h4;
    localparam logic [3:0] OP_ADD    = 4'h5;
    localparam logic [3:0] OP_ADD_I  = 4'h6;
    localparam logic [3:0] OP_JUMP   = 4'hB;
    localparam logic [3:0] OP_HALT   = 4'hC;

    localparam logic [7:0] SCREEN_ADDR = 8'h00;
    localparam logic [RIDX_W-1:0] REG_ZERO = '0;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_EXEC  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_SCREEN  = 2'd1,
        ST_HALT    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        U_IDLE, U_WR, U_RD, U_RDL, U_F1, U_F2, U_F3,
        U_LD_A, U_LD_B, U_LDI, U_ST_A, U_ST_B, U_MOV_A, U_MOV_B,
        U_ADD_A, U_ADD_B, U_JMP_A, U_JMP_B, U_HLT, U_INV, U_OUT
    } t_upc;

    typedef enum logic [1:0] {MEM_NONE, MEM_RD, MEM_WR} t_mem_op;
    typedef enum logic [1:0] {MA_REQ, MA_PC, MA_LO} t_maddr;
    typedef enum logic {MW_REQ, MW_REGA} t_mwdat;
    typedef enum logic [1:0] {LAT_NONE, LAT_HI, LAT_LO, LAT_RD} t_lat;
    typedef enum logic [1:0] {RS_R, RS_X, RS_Y, RS_ZERO} t_rsel;
    typedef enum logic [1:0] {WD_MEM, WD_LO, WD_REGA, WD_SUM} t_wsel;
    typedef enum logic [1:0] {SQ_GO, SQ_REQ, SQ_OP, SQ_OUT} t_seq;

    typedef struct packed {
        t_mem_op mem;
        t_maddr  maddr;
        t_mwdat  mwdat;
        logic    st_chk;
        logic    pc_inc;
        logic    pc_jeq;
        t_lat    lat;
        t_rsel   rsel_a;
        t_rsel   rsel_b;
        logic    rf_wr;
        t_rsel   rsel_w;
        t_wsel   wsel;
        logic    stat_set;
        t_status stat;
        logic    out_ld;
        t_seq    seq;
        t_upc    next;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mem: MEM_NONE, maddr: MA_REQ, mwdat: MW_REQ, st_chk: 1'b0,
        pc_inc: 1'b0, pc_jeq: 1'b0, lat: LAT_NONE, rsel_a: RS_R,
        rsel_b: RS_Y, rf_wr: 1'b0, rsel_w: RS_R, wsel: WD_MEM,
        stat_set: 1'b0, stat: ST_DONE, out_ld: 1'b0, seq: SQ_GO,
        next: U_IDLE
    };

    function automatic t_uword f_ucode(input t_upc u);
        t_uword w;
        w = UW_NOP;
        w.next = U_OUT;
        case (u)
            U_IDLE: begin
                w.seq = SQ_REQ;
            end
            U_WR: begin
                w.mem = MEM_WR;
            end
            U_RD: begin
                w.mem  = MEM_RD;
                w.next = U_RDL;
            end
            U_RDL: begin
                w.lat = LAT_RD;
            end
            U_F1: begin
                w.mem    = MEM_RD;
                w.maddr  = MA_PC;
                w.pc_inc = 1'b1;
                w.next   = U_F2;
            end
            U_F2: begin
                w.mem    = MEM_RD;
                w.maddr  = MA_PC;
                w.pc_inc = 1'b1;
                w.lat    = LAT_HI;
                w.next   = U_F3;
            end
            U_F3: begin
                w.lat = LAT_LO;
                w.seq = SQ_OP;
            end
            U_LD_A: begin
                w.mem   = MEM_RD;
                w.maddr = MA_LO;
                w.next  = U_LD_B;
            end
            U_LD_B: begin
                w.rf_wr = 1'b1;
                w.wsel  = WD_MEM;
            end
            U_LDI: begin
                w.rf_wr = 1'b1;
                w.wsel  = WD_LO;
            end
            U_ST_A: begin
                w.rsel_a = RS_R;
                w.next   = U_ST_B;
            end
            U_ST_B: begin
                w.mem    = MEM_WR;
                w.maddr  = MA_LO;
                w.mwdat  = MW_REGA;
                w.st_chk = 1'b1;
            end
            U_MOV_A: begin
                w.rsel_a = RS_X;
                w.next   = U_MOV_B;
            end
            U_MOV_B: begin
                w.rf_wr  = 1'b1;
                w.rsel_w = RS_Y;
                w.wsel   = WD_REGA;
            end
            U_ADD_A: begin
                w.rsel_a = RS_X;
                w.rsel_b = RS_Y;
                w.next   = U_ADD_B;
            end
            U_ADD_B: begin
                w.rf_wr = 1'b1;
                w.wsel  = WD_SUM;
            end
            U_JMP_A: begin
                w.rsel_a = RS_R;
                w.rsel_b = RS_ZERO;
                w.next   = U_JMP_B;
            end
            U_JMP_B: begin
                w.pc_jeq = 1'b1;
            end
            U_HLT: begin
                w.stat_set = 1'b1;
                w.stat     = ST_HALT;
            end
            U_INV: begin
                w.stat_set = 1'b1;
                w.stat     = ST_INVALID;
            end
            U_OUT: begin
                w.out_ld = 1'b1;
                w.seq    = SQ_OUT;
                w.next   = U_IDLE;
            end
            default: begin
                w.next = U_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_upc f_req_target(input t_req r);
        t_upc t;
        case (r)
            REQ_WRITE: t = U_WR;
            REQ_READ:  t = U_RD;
            REQ_EXEC:  t = U_F1;
            default:   t = U_OUT;
        endcase
        return t;
    endfunction

    function automatic t_upc f_op_target(input logic [3:0] op);
        t_upc t;
        case (op)
            OP_LOAD:  t = U_LD_A;
            OP_LOADI: t = U_LDI;
            OP_STORE: t = U_ST_A;
            OP_MOVE:  t = U_MOV_A;
            OP_ADD:   t = U_ADD_A;
            OP_ADD_I: t = U_ADD_A;
            OP_JUMP:  t = U_JMP_A;
            OP_HALT:  t = U_HLT;
            default:  t = U_INV;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vcpu_mem.sv =====
`default_nettype none
module vcpu_mem
    import vcpu_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  [7:0] i_addr,
    input  wire        i_we,
    input  wire        i_re,
    input  wire  [7:0] i_wdata,
    output logic [7:0] o_q
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [AW-1:0]        idx;
    logic [7:0]           r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [7:0]           r_q;
    logic                 r_qv;

    // byte address folded onto the array depth
    always_comb begin
        idx = '0;
        for (int i = 0; i < 256; i++) begin
            if (i_addr == 8'(i)) begin
                idx = AW'(i % MEM_DEPTH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[idx] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[idx] <= 1'b1;
            end
            if (i_re) begin
                r_qv <= r_vld[idx];
            end
        end
    end

    assign o_q = r_qv ? r_q : 8'h00;

endmodule
`default_nettype wire

// ===== rtl/vcpu_regfile.sv =====
`default_nettype none
module vcpu_regfile
    import vcpu_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [RIDX_W-1:0] i_ra,
    input  wire  [RIDX_W-1:0] i_rb,
    input  wire               i_we,
    input  wire  [RIDX_W-1:0] i_wa,
    input  wire  [7:0]        i_wd,
    output logic [7:0]        o_qa,
    output logic [7:0]        o_qb
);

    logic [7:0]           r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [7:0]           r_qa;
    logic [7:0]           r_qb;
    logic                 r_qva;
    logic                 r_qvb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rf[i_wa] <= i_wd;
        end
        r_qa <= r_rf[i_ra];
        r_qb <= r_rf[i_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qva <= 1'b0;
            r_qvb <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wa] <= 1'b1;
            end
            r_qva <= r_vld[i_ra];
            r_qvb <= r_vld[i_rb];
        end
    end

    assign o_qa = r_qva ? r_qa : 8'h00;
    assign o_qb = r_qvb ? r_qb : 8'h00;

endmodule
`default_nettype wire

// ===== rtl/vcpu_seq.sv =====
`default_nettype none
module vcpu_seq
    import vcpu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_fire,
    input  t_req        i_req,
    input  wire  [3:0]  i_op,
    input  wire         i_slot_free,
    output t_uword      o_cw
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword cw;

    always_comb begin
        cw = f_ucode(r_upc);
    end

    always_comb begin
        n_upc = r_upc;
        case (cw.seq)
            SQ_GO:   n_upc = cw.next;
            SQ_REQ:  n_upc = i_fire ? f_req_target(i_req) : r_upc;
            SQ_OP:   n_upc = f_op_target(i_op);
            SQ_OUT:  n_upc = i_slot_free ? cw.next : r_upc;
            default: n_upc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        o_cw = cw;
    end

endmodule
`default_nettype wire

// ===== rtl/vole_cpu_instruction_step_top.sv =====
`default_nettype none
// Requests are taken only while the sequencer is idle; a further request is taken
// only once the last result is loaded into the output register, which waits while
// that register still holds an untransferred result. The microprogram walks the
// single-port memory: an execute does two fetch reads, then at most one data access.
// Reset: pc, opcode byte and sequencer cleared; memory and register valid
// bits cleared at once, so both read as zero; no clearing pass.
module vole_cpu_instruction_step_top
    import vcpu_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // mem_addr[7:0], mem_data[15:8]
    input  wire  [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // screen_value[7:0], read_data[15:8],
                                     // program_counter[23:16], instruction_word[39:24]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    t_uword      cw;
    logic        fire;
    logic        slot_free;
    logic        out_ld;
    logic        to_screen;
    logic        mem_we;
    logic [7:0]  mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_q;
    logic [7:0]  qa;
    logic [7:0]  qb;
    logic [7:0]  rf_wd;
    logic [7:0]  sum;

    logic [7:0]  r_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_pc;
    logic [7:0]  r_hi;
    logic [7:0]  r_lo;
    t_status     r_status;
    logic [7:0]  r_screen;
    logic [7:0]  r_rdata;
    logic        r_out_valid;
    logic [39:0] r_m_data;
    logic [1:0]  r_m_user;

    function automatic logic [RIDX_W-1:0] f_rsel(input t_rsel s, input logic [7:0] hi,
                                                 input logic [7:0] lo);
        logic [RIDX_W-1:0] r;
        case (s)
            RS_R:    r = hi[RIDX_W-1:0];
            RS_X:    r = lo[7:4];
            RS_Y:    r = lo[RIDX_W-1:0];
            default: r = REG_ZERO;
        endcase
        return r;
    endfunction

    assign fire      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (cw.seq == SQ_REQ);
    assign slot_free = !r_out_valid || i_m_tready;
    assign out_ld    = cw.out_ld && slot_free;
    assign to_screen = cw.st_chk && (r_lo == SCREEN_ADDR);
    assign mem_we    = (cw.mem == MEM_WR) && !to_screen;
    assign sum       = qa + qb;

    always_comb begin
        case (cw.maddr)
            MA_REQ:  mem_addr = r_addr;
            MA_PC:   mem_addr = r_pc;
            default: mem_addr = r_lo;
        endcase
        case (cw.mwdat)
            MW_REGA: mem_wdata = qa;
            default: mem_wdata = r_data;
        endcase
        case (cw.wsel)
            WD_MEM:  rf_wd = mem_q;
            WD_LO:   rf_wd = r_lo;
            WD_REGA: rf_wd = qa;
            default: rf_wd = sum;
        endcase
    end

    vcpu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (t_req'(i_s_tuser)),
        .i_op        (r_hi[7:4]),
        .i_slot_free (slot_free),
        .o_cw        (cw)
    );

    vcpu_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (mem_addr),
        .i_we    (mem_we),
        .i_re    (cw.mem == MEM_RD),
        .i_wdata (mem_wdata),
        .o_q     (mem_q)
    );

    vcpu_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ra    (f_rsel(cw.rsel_a, r_hi, r_lo)),
        .i_rb    (f_rsel(cw.rsel_b, r_hi, r_lo)),
        .i_we    (cw.rf_wr),
        .i_wa    (f_rsel(cw.rsel_w, r_hi, r_lo)),
        .i_wd    (rf_wd),
        .o_qa    (qa),
        .o_qb    (qb)
    );

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_addr   <= i_s_tdata[7:0];
            r_data   <= i_s_tdata[15:8];
            r_status <= ST_DONE;
            r_screen <= 8'h00;
            r_rdata  <= 8'h00;
            r_lo     <= 8'h00;
        end else begin
            if (cw.lat == LAT_LO) begin
                r_lo <= mem_q;
            end
            if (cw.lat == LAT_RD) begin
                r_rdata <= mem_q;
            end
            if (to_screen) begin
                r_status <= ST_SCREEN;
                r_screen <= qa;
            end
            if (cw.stat_set) begin
                r_status <= cw.stat;
            end
        end
        if (out_ld) begin
            r_m_data <= {r_hi, r_lo, r_pc, r_rdata, r_screen};
            r_m_user <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= 8'h00;
            r_hi        <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_hi <= 8'h00;
            end else if (cw.lat == LAT_HI) begin
                r_hi <= mem_q;
            end
            if (cw.pc_inc) begin
                r_pc <= r_pc + 8'd1;
            end else if (cw.pc_jeq && (qa == qb)) begin
                r_pc <= r_lo;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> !o_s_tready)
        else $error("request taken while sequencer busy");

    a_no_screen_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.st_chk && mem_we) |-> (r_lo != SCREEN_ADDR))
        else $error("store to screen address reached memory");

    a_screen_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ld && (r_status == ST_SCREEN)) |-> (r_lo == SCREEN_ADDR && r_hi[7:4] == OP_STORE))
        else $error("screen status without store to screen address");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !out_ld)
        else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

// ===== sim/vole_cpu_instruction_step_top_test.sv =====
module vole_cpu_instruction_step_top_test;
    import vcpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int MEM_BYTES    = 256;
    localparam int ITEM_TARGET  = 2000;
    localparam int PAUSE_EVERY  = 700;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DIR_ROWS     = 28;

    typedef struct packed {
        t_status     status;
        logic [7:0]  screen_value;
        logic [7:0]  read_data;
        logic [7:0]  pc;
        logic [15:0] instr_word;
    } cpu_result_t;

    typedef struct packed {
        t_req        req;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic        fixed;   // 1: use the typed-in result
        cpu_result_t want;
    } req_row_t;

    localparam cpu_result_t NO_RES = '{ST_DONE, 8'h00, 8'h00, 8'h00, 16'h0000};

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // mem_addr[7:0], mem_data[15:8]
    logic [1:0]  i_s_tuser  = '0;   // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // screen_value[7:0], read_data[15:8],
                                    // program_counter[23:16], instruction_word[39:24]
    logic [1:0]  o_m_tuser;         // status[1:0]

    vole_cpu_instruction_step_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow CPU state
    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  reg_img [16];
    logic [7:0]  pc_img;
    logic [7:0]  opc_img;

    cpu_result_t pending_results [$];
    int          errors      = 0;
    int          n_items     = 0;
    int          n_exec      = 0;
    int          n_results   = 0;
    int          st_count [4] = '{0, 0, 0, 0};
    int          burst_left  = 0;
    int          cyc         = 0;
    int          stall_mode  = 0;
    int          idle_cycles = 0;
    cpu_result_t got_res;
    cpu_result_t want_res;

    function automatic cpu_result_t apply_request(input t_req req, input logic [7:0] addr,
                                                  input logic [7:0] data);
        cpu_result_t res;
        logic [7:0]  lo;
        logic [3:0]  r;
        logic [3:0]  x;
        logic [3:0]  y;
        res = NO_RES;
        case (req)
            REQ_WRITE: mem_img[addr] = data;
            REQ_READ:  res.read_data = mem_img[addr];
            REQ_EXEC: begin
                opc_img = mem_img[pc_img];
                pc_img  = pc_img + 8'd1;
                lo      = mem_img[pc_img];
                pc_img  = pc_img + 8'd1;
                res.instr_word = {opc_img, lo};
                r = opc_img[3:0];
                x = lo[7:4];
                y = lo[3:0];
                case (opc_img[7:4])
                    OP_LOAD:  reg_img[r] = mem_img[lo];
                    OP_LOADI: reg_img[r] = lo;
                    OP_STORE: begin
                        if (lo == SCREEN_ADDR) begin
                            res.status       = ST_SCREEN;
                            res.screen_value = reg_img[r];
                        end else begin
                            mem_img[lo] = reg_img[r];
                        end
                    end
                    OP_MOVE:  reg_img[y] = reg_img[x];
                    OP_ADD, OP_ADD_I: reg_img[r] = reg_img[x] + reg_img[y];
                    OP_JUMP: begin
                        if (reg_img[r] == reg_img[REG_ZERO]) pc_img = lo;
                    end
                    OP_HALT:  res.status = ST_HALT;
                    default:  res.status = ST_INVALID;
                endcase
            end
            default: ;
        endcase
        res.pc = pc_img;
        return res;
    endfunction

    task automatic send_request(input t_req req, input logic [7:0] addr,
                                input logic [7:0] data, input logic fixed,
                                input cpu_result_t want);
        cpu_result_t pred;
        int          gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {data, addr};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = apply_request(req, addr, data);
        pending_results = {pending_results, (fixed ? want : pred)};
        if (req != REQ_NONE) n_items++;
        if (req == REQ_EXEC) n_exec++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // receiver: stall pattern re-drawn at random from four modes
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            2:       i_m_tready <= (cyc % 5 != 0);
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (o_m_tvalid && i_m_tready) begin
            got_res = '{t_status'(o_m_tuser), o_m_tdata[7:0], o_m_tdata[15:8],
                        o_m_tdata[23:16], o_m_tdata[39:24]};
            n_results++;
            st_count[got_res.status]++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got_res);
            end else begin
                want_res = pending_results.pop_front();
                check_field("status", want_res.status, got_res.status);
                check_field("screen_value", want_res.screen_value, got_res.screen_value);
                check_field("read_data", want_res.read_data, got_res.read_data);
                check_field("program_counter", want_res.pc, got_res.pc);
                check_field("instruction_word", want_res.instr_word, got_res.instr_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        req_row_t    rows [DIR_ROWS];
        int          next_pause;
        int          pick;
        logic [3:0]  op;
        logic [3:0]  rn;
        logic [7:0]  lo;
        logic [7:0]  at;

        for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = 8'h00;
        for (int i = 0; i < 16; i++) reg_img[i] = 8'h00;
        pc_img  = 8'h00;
        opc_img = 8'h00;

        // short program walked from reset; pc starts at 00
        rows[0]  = '{REQ_READ,  8'h00, 8'h00, 1'b1, NO_RES};
        rows[1]  = '{REQ_NONE,  8'h5A, 8'hA5, 1'b1, NO_RES};
        rows[2]  = '{REQ_EXEC,  8'h00, 8'h00, 1'b1,
                     '{ST_INVALID, 8'h00, 8'h00, 8'h02, 16'h0000}};
        rows[3]  = '{REQ_WRITE, 8'h02, 8'h21, 1'b0, NO_RES};
        rows[4]  = '{REQ_WRITE, 8'h03, 8'hFF, 1'b0, NO_RES};
        rows[5]  = '{REQ_EXEC,  8'hFF, 8'hFF, 1'b0, NO_RES};   // R1 = FF
        rows[6]  = '{REQ_WRITE, 8'h04, 8'h51, 1'b0, NO_RES};
        rows[7]  = '{REQ_WRITE, 8'h05, 8'h11, 1'b0, NO_RES};
        rows[8]  = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // R1 = R1 + R1, wraps
        rows[9]  = '{REQ_WRITE, 8'h06, 8'h40, 1'b0, NO_RES};
        rows[10] = '{REQ_WRITE, 8'h07, 8'h1F, 1'b0, NO_RES};
        rows[11] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // R15 = R1
        rows[12] = '{REQ_WRITE, 8'h08, 8'h3F, 1'b0, NO_RES};
        rows[13] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // store to screen
        rows[14] = '{REQ_WRITE, 8'h0A, 8'h6F, 1'b0, NO_RES};
        rows[15] = '{REQ_WRITE, 8'h0B, 8'hF1, 1'b0, NO_RES};
        rows[16] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // R15 = R15 + R1
        rows[17] = '{REQ_WRITE, 8'h0C, 8'hC0, 1'b0, NO_RES};
        rows[18] = '{REQ_EXEC,  8'h00, 8'h00, 1'b1,
                     '{ST_HALT, 8'h00, 8'h00, 8'h0E, 16'hC000}};
        rows[19] = '{REQ_WRITE, 8'h0E, 8'hB2, 1'b0, NO_RES};
        rows[20] = '{REQ_WRITE, 8'h0F, 8'hFE, 1'b0, NO_RES};
        rows[21] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // taken jump to FE
        rows[22] = '{REQ_WRITE, 8'hFE, 8'h13, 1'b0, NO_RES};
        rows[23] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // load, pc wraps
        rows[24] = '{REQ_WRITE, 8'h00, 8'h3F, 1'b0, NO_RES};
        rows[25] = '{REQ_WRITE, 8'h01, 8'hFF, 1'b0, NO_RES};
        rows[26] = '{REQ_EXEC,  8'h00, 8'h00, 1'b0, NO_RES};   // store to memory
        rows[27] = '{REQ_READ,  8'hFF, 8'h00, 1'b0, NO_RES};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(rows[i].req, rows[i].addr, rows[i].data, rows[i].fixed,
                         rows[i].want);
        end

        next_pause = PAUSE_EVERY;
        while (n_items < ITEM_TARGET) begin
            if (n_items >= next_pause) begin
                i_s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
                next_pause += PAUSE_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // plant an instruction at pc, then run it
                if ($urandom_range(0, 9) == 0) begin
                    do op = 4'($urandom_range(0, 15));
                    while (op inside {OP_LOAD, OP_LOADI, OP_STORE, OP_MOVE, OP_ADD,
                                      OP_ADD_I, OP_JUMP, OP_HALT});
                end else begin
                    case ($urandom_range(0, 7))
                        0:       op = OP_LOAD;
                        1:       op = OP_LOADI;
                        2:       op = OP_STORE;
                        3:       op = OP_MOVE;
                        4:       op = OP_ADD;
                        5:       op = OP_ADD_I;
                        6:       op = OP_JUMP;
                        default: op = OP_HALT;
                    endcase
                end
                rn = 4'($urandom_range(0, 15));
                lo = 8'($urandom);
                if (op == OP_STORE && $urandom_range(0, 3) == 0) lo = SCREEN_ADDR;
                if (op == OP_JUMP && $urandom_range(0, 2) == 0) rn = REG_ZERO;
                at = pc_img;
                send_request(REQ_WRITE, at, {op, rn}, 1'b0, NO_RES);
                send_request(REQ_WRITE, at + 8'd1, lo, 1'b0, NO_RES);
                send_request(REQ_EXEC, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            end else if (pick < 62) begin
                send_request(REQ_EXEC, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            end else if (pick < 80) begin
                send_request(REQ_WRITE, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            end else if (pick < 95) begin
                send_request(REQ_READ, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            end else begin
                send_request(REQ_NONE, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d memory and execute requests (%0d executes), %0d results checked.",
                 n_items, n_exec, n_results);
        $display("Result status: done %0d, screen %0d, halt %0d, invalid %0d.",
                 st_count[ST_DONE], st_count[ST_SCREEN], st_count[ST_HALT],
                 st_count[ST_INVALID]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== vole_cpu_instruction_step_top.f =====
rtl/vcpu_pkg.sv
rtl/vcpu_mem.sv
rtl/vcpu_regfile.sv
rtl/vcpu_seq.sv
rtl/vole_cpu_instruction_step_top.sv
sim/vole_cpu_instruction_step_top_test.sv
